[hw/rtl/motion_queue_in_position_check_macros.svh]
// Assertion macros for the file that checks its own logic.
// The three-argument form uses the usual clock and reset names of the block.
`ifndef MOTION_QUEUE_IN_POSITION_CHECK_MACROS_SVH
`define MOTION_QUEUE_IN_POSITION_CHECK_MACROS_SVH

`ifndef SYNTH

`define MQIP_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define MQIP_ASSERT(name, prop, msg) \
  `MQIP_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`else

`define MQIP_ASSERT_CLK(name, clk, rstn, prop, msg)

`define MQIP_ASSERT(name, prop, msg)

`endif

`endif

[hw/rtl/mqip_pkg.sv]
`default_nettype none

package mqip_pkg;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_STATUS  = 2'd1;
  localparam logic [1:0] CMD_CANCEL  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED = 8'd1;

  localparam logic [31:0] ERROR_LIMIT_RESET   = 32'd100;
  localparam logic [15:0] STABLE_NEEDED_RESET = 16'd5;

  // Drive control and status word bits.
  localparam logic [15:0] CW_ENABLE       = 16'h000F;
  localparam logic [15:0] CW_NEW_SETPOINT = 16'h0010;
  localparam logic [15:0] CW_IMMEDIATE    = 16'h0020;
  localparam logic [15:0] CW_RELATIVE     = 16'h0040;
  localparam logic [15:0] CW_HALT         = 16'h0100;
  localparam int unsigned SW_TARGET_REACHED = 10;

  localparam logic [3:0] MIN_FRAME_LEN = 4'd6;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam int unsigned DROP_W       = 5;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SETPOINT = 3'd1,
    EV_COMPLETE = 3'd2,
    EV_CANCEL   = 3'd3,
    EV_FULL     = 3'd4
  } event_e;

  typedef struct packed {
    logic               immediate;
    logic               relative;
    logic signed [31:0] position;
  } move_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] goal_pos;
    logic               relative_move;
    logic               immediate_move;
    logic [3:0]         frame_length;
    logic [15:0]        drive_status;
    logic signed [31:0] meas_pos;
  } in_item_t;

  typedef struct packed {
    event_e             event_res;
    logic [15:0]        control_out;
    logic signed [31:0] setpoint_position;
    logic [DROP_W-1:0]  dropped_moves;
    logic               moving;
    logic               last_result;
  } result_t;

  // One or two results written to the result queue in a cycle.
  typedef struct packed {
    logic    push;
    logic    pair;
    result_t first;
    result_t second;
  } result_wr_t;

  function automatic logic [15:0] setpoint_control(move_t m);
    logic [15:0] cw;
    cw = CW_ENABLE | CW_NEW_SETPOINT;
    if (m.relative) cw = cw | CW_RELATIVE;
    if (m.immediate) cw = cw | CW_IMMEDIATE;
    return cw;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mqip_store.sv]
`default_nettype none

// Move storage. The read port always looks one entry past the next head,
// so the following move is ready when the active one completes.
module mqip_store #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire mqip_pkg::move_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output mqip_pkg::move_t      rdata_o
);
  import mqip_pkg::*;

  move_t mem [QUEUE_DEPTH];
  move_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // A write to the entry being read is forwarded.
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/mqip_res_fifo.sv]
`default_nettype none

// Four-entry result queue; takes one or two results per cycle.
module mqip_res_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mqip_pkg::result_wr_t wr_i,
  output logic [2:0]                cnt_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output mqip_pkg::result_t         data_o
);
  import mqip_pkg::*;

  result_t    buf_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] n_push;
  logic       pop;

  assign pop    = (cnt_q != 3'd0) && ready_i;
  assign n_push = wr_i.push ? (wr_i.pair ? 2'd2 : 2'd1) : 2'd0;

  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    cnt_d    = cnt_q + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      buf_q[wr_ptr_q] <= wr_i.first;
    end
    if (wr_i.push && wr_i.pair) begin
      buf_q[wr_ptr_q + 2'd1] <= wr_i.second;
    end
  end

  assign cnt_o   = cnt_q;
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = buf_q[rd_ptr_q];

endmodule

`default_nettype wire

[hw/rtl/mqip_ctrl.sv]
`default_nettype none

// Input register, queue pointers, in-position counter and the per-item
// update that produces the results.
module mqip_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire mqip_pkg::in_item_t                in_item_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [mqip_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [31:0]                       cfg_data_i,
  input  wire logic                              res_room_i,
  output mqip_pkg::result_wr_t                   res_wr_o,
  output logic                                   st_we_o,
  output logic [AW-1:0]                          st_waddr_o,
  output mqip_pkg::move_t                        st_wdata_o,
  output logic [AW-1:0]                          st_raddr_o,
  input  wire mqip_pkg::move_t                   st_rdata_i
);
  import mqip_pkg::*;

  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  logic        in_vld_q;
  in_item_t    in_q;
  logic        fire;

  logic [31:0] limit_q;
  logic [15:0] need_q;

  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0]   count_q, count_d;
  logic [15:0]   ctrl_q, ctrl_d;
  move_t         act_q, act_d;

  move_t              new_move;
  logic [AW:0]        tail_sum;
  logic [AW-1:0]      tail;
  logic [AW-1:0]      head_next;
  logic [AW-1:0]      head_d_next;
  logic signed [32:0] pos_err;
  logic signed [32:0] lim_pos;
  logic signed [32:0] lim_neg;
  logic               on_target;
  logic [15:0]        count_inc;
  logic               busy;
  result_t            res0, res1;
  logic               pair;

  assign fire       = in_vld_q && res_room_i;
  assign in_ready_o = !in_vld_q || fire;
  assign busy       = (fill_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ERROR_LIMIT_RESET;
      need_q  <= STABLE_NEEDED_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_ERROR_LIMIT) begin
        limit_q <= cfg_data_i;
      end else if (cfg_index_i == REG_STABLE_NEEDED) begin
        need_q <= cfg_data_i[15:0];
      end
    end
  end

  always_comb begin
    new_move.immediate = in_q.immediate_move;
    new_move.relative  = in_q.relative_move;
    new_move.position  = in_q.goal_pos;

    // Free slot is head plus fill, wrapped at the queue depth.
    tail_sum = (AW + 1)'(head_q) + (AW + 1)'(fill_q);
    if (tail_sum >= DEPTH_S) begin
      tail_sum = tail_sum - DEPTH_S;
    end
    tail      = tail_sum[AW-1:0];
    head_next = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);

    // Exact error on the 33-bit difference, checked against +/- limit.
    pos_err   = $signed({in_q.meas_pos[31], in_q.meas_pos})
              - $signed({act_q.position[31], act_q.position});
    lim_pos   = $signed({1'b0, limit_q});
    lim_neg   = -lim_pos;
    on_target = in_q.drive_status[SW_TARGET_REACHED]
              && (pos_err <= lim_pos) && (pos_err >= lim_neg);
    count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;
  end

  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    count_d = count_q;
    ctrl_d  = ctrl_q;
    act_d   = act_q;
    res0    = '0;
    res1    = '0;
    pair    = 1'b0;
    st_we_o = 1'b0;

    unique case (in_q.command)
      CMD_ENQUEUE: begin
        if (fill_q == FW'(QUEUE_DEPTH)) begin
          res0.event_res = EV_FULL;
        end else begin
          st_we_o = fire;
          fill_d  = fill_q + FW'(1);
          if (!busy) begin
            act_d   = new_move;
            ctrl_d  = setpoint_control(new_move);
            count_d = '0;
            res0.event_res         = EV_SETPOINT;
            res0.control_out       = setpoint_control(new_move);
            res0.setpoint_position = new_move.position;
          end
        end
      end
      CMD_STATUS: begin
        if ((in_q.frame_length >= MIN_FRAME_LEN) && busy) begin
          if (on_target) begin
            if (count_inc >= need_q) begin
              res0.event_res = EV_COMPLETE;
              head_d  = head_next;
              fill_d  = fill_q - FW'(1);
              count_d = '0;
              // The next queued move goes out with the completion.
              if (fill_q > FW'(1)) begin
                pair    = 1'b1;
                act_d   = st_rdata_i;
                ctrl_d  = setpoint_control(st_rdata_i);
                res1.event_res         = EV_SETPOINT;
                res1.control_out       = setpoint_control(st_rdata_i);
                res1.setpoint_position = st_rdata_i.position;
              end
            end else begin
              count_d = count_inc;
            end
          end else begin
            count_d = '0;
          end
        end
      end
      CMD_CANCEL: begin
        if (busy) begin
          ctrl_d  = ctrl_q | CW_HALT;
          head_d  = '0;
          fill_d  = '0;
          count_d = '0;
          res0.event_res     = EV_CANCEL;
          res0.control_out   = ctrl_q | CW_HALT;
          res0.dropped_moves = DROP_W'(fill_q);
        end
      end
      default: begin
      end
    endcase

    res0.moving      = (fill_d != '0);
    res1.moving      = (fill_d != '0);
    res0.last_result = !pair;
    res1.last_result = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      fill_q  <= '0;
      count_q <= '0;
      ctrl_q  <= '0;
    end else if (fire) begin
      head_q  <= head_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      ctrl_q  <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      act_q <= act_d;
    end
  end

  // The store reads the entry after the head that holds once this cycle ends.
  always_comb begin
    if (fire) begin
      head_d_next = (head_d == LAST_IDX) ? '0 : head_d + AW'(1);
    end else begin
      head_d_next = head_next;
    end
  end

  assign st_raddr_o = head_d_next;
  assign st_waddr_o = tail;
  assign st_wdata_o = new_move;

  assign res_wr_o.push   = fire;
  assign res_wr_o.pair   = pair;
  assign res_wr_o.first  = res0;
  assign res_wr_o.second = res1;

endmodule

`default_nettype wire

[hw/rtl/motion_queue_in_position_check.sv]
`default_nettype none

// Position-move queue with in-position confirmation. Commands arrive on the
// slave stream (tuser selects enqueue, status frame or cancel); results leave
// on the master stream, one or two per item, with tlast on the final one.
// The block accepts one item per clock while the result queue has room. Each
// item passes an input register, a combinational update of the queue, counter
// and control word, and a four-entry result queue. Input is held off while the
// result queue has fewer than two free entries; a completion that issues the
// next move produces two results and so takes two output transfers.
// Configuration writes are accepted every cycle and must only be made while no
// item is in flight.
`include "motion_queue_in_position_check_macros.svh"

module motion_queue_in_position_check #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] goal_pos, [32] relative_move, [33] immediate_move,
  // [37:34] frame_length, [53:38] drive_status, [85:54] meas_pos
  input  wire logic [87:0]                    s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]                     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [15:0] control_out, [47:16] setpoint_position, [52:48] dropped_moves,
  // [53] moving
  output logic [55:0]                         m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mqip_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i
);
  import mqip_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  in_item_t   in_item;
  result_wr_t res_wr;
  result_t    res_out;
  logic [2:0] res_cnt;
  logic       res_room;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] st_raddr;
  move_t         st_wdata;
  move_t         st_rdata;

  logic          pair_ok;
  logic          cancel_ok;

  assign in_item.command         = s_axis_tuser;
  assign in_item.goal_pos        = $signed(s_axis_tdata[31:0]);
  assign in_item.relative_move   = s_axis_tdata[32];
  assign in_item.immediate_move  = s_axis_tdata[33];
  assign in_item.frame_length    = s_axis_tdata[37:34];
  assign in_item.drive_status    = s_axis_tdata[53:38];
  assign in_item.meas_pos        = $signed(s_axis_tdata[85:54]);

  assign cfg_ready_o = 1'b1;
  assign res_room    = (res_cnt <= 3'd2);

  mqip_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .res_room_i (res_room),
    .res_wr_o   (res_wr),
    .st_we_o    (st_we),
    .st_waddr_o (st_waddr),
    .st_wdata_o (st_wdata),
    .st_raddr_o (st_raddr),
    .st_rdata_i (st_rdata)
  );

  mqip_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  mqip_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_wr),
    .cnt_o  (res_cnt),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (res_out)
  );

  assign m_axis_tdata = {2'b00, res_out.moving, res_out.dropped_moves,
                         res_out.setpoint_position, res_out.control_out};
  assign m_axis_tuser = res_out.event_res;
  assign m_axis_tlast = res_out.last_result;

  // A result pair is always a completion followed by the next setpoint.
  assign pair_ok   = (res_wr.first.event_res == EV_COMPLETE)
                  && (res_wr.second.event_res == EV_SETPOINT) && res_wr.second.moving;
  assign cancel_ok = (res_wr.first.event_res != EV_CANCEL)
                  || (!res_wr.first.moving && !res_wr.pair && res_wr.first.last_result);

  `MQIP_ASSERT(a_res_no_overflow, res_wr.push |-> res_cnt <= 3'd2, "result queue overrun")
  `MQIP_ASSERT(a_res_cnt_bound, res_cnt <= 3'd4, "result queue count out of range")
  `MQIP_ASSERT(a_pair_after_complete, res_wr.push && res_wr.pair |-> pair_ok, "bad result pair")
  `MQIP_ASSERT(a_cancel_idle, res_wr.push |-> cancel_ok, "cancel left block moving")

endmodule

`default_nettype wire

[tb/sv/motion_queue_in_position_check_tb.sv]
`timescale 1ns / 1ps

module motion_queue_in_position_check_tb;
  import mqip_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_MAP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 8'hFF;
  localparam logic [15:0] TARGET_BIT = 16'h1 << SW_TARGET_REACHED;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam int unsigned HOLD_OFF_CYCLES = 250;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 307;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  motion_queue_in_position_check #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's queue, counter and registers.
  move_t move_store[QUEUE_DEPTH];
  logic [3:0] q_head = '0;
  logic [4:0] q_fill = '0;
  logic q_busy = 1'b0;
  logic [15:0] stable_frames = '0;
  logic [15:0] last_ctrl = '0;
  logic [31:0] err_limit = ERROR_LIMIT_RESET;
  logic [15:0] frames_needed = STABLE_NEEDED_RESET;

  in_item_t pending_items[$];
  result_t awaited_results[$];
  in_item_t item_on_bus;
  result_t seen, want;
  logic holding;

  int items_queued = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 1;
  int n_setpoints = 0;
  int n_completions = 0;
  int n_cancels = 0;
  int n_rejects = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  wire send_steady = (items_sent >= 600) && (items_sent < 900);
  wire recv_steady = (results_seen >= 650) && (results_seen < 950);

  function automatic result_t issue_head_move();
    result_t r;
    move_t m;
    r = '0;
    m = move_store[q_head];
    last_ctrl = CW_ENABLE | CW_NEW_SETPOINT;
    if (m.relative) last_ctrl = last_ctrl | CW_RELATIVE;
    if (m.immediate) last_ctrl = last_ctrl | CW_IMMEDIATE;
    q_busy = 1'b1;
    stable_frames = '0;
    r.event_res = EV_SETPOINT;
    r.control_out = last_ctrl;
    r.setpoint_position = m.position;
    return r;
  endfunction

  function automatic void predict_move_results(in_item_t it);
    result_t r0, r1;
    move_t m;
    longint diff;
    int n;
    r0 = '0;
    r1 = '0;
    r0.event_res = EV_NONE;
    n = 1;
    case (it.command)
      CMD_ENQUEUE: begin
        if (q_fill >= QUEUE_DEPTH) begin
          r0.event_res = EV_FULL;
        end else begin
          m.position = it.goal_pos;
          m.relative = it.relative_move;
          m.immediate = it.immediate_move;
          move_store[(int'(q_head) + int'(q_fill)) % QUEUE_DEPTH] = m;
          q_fill = q_fill + 1'b1;
          if (!q_busy) r0 = issue_head_move();
        end
      end
      CMD_STATUS: begin
        if (it.frame_length >= MIN_FRAME_LEN && q_busy && q_fill > 0) begin
          // The error is taken on the full signed difference, without wrapping.
          diff = longint'($signed(it.meas_pos))
               - longint'($signed(move_store[q_head].position));
          if (diff < 0) diff = -diff;
          if (it.drive_status[SW_TARGET_REACHED] && diff <= longint'(err_limit)) begin
            if (stable_frames != COUNT_MAX) stable_frames = stable_frames + 1'b1;
            if (stable_frames >= frames_needed) begin
              r0.event_res = EV_COMPLETE;
              q_head = q_head + 1'b1;
              q_fill = q_fill - 1'b1;
              stable_frames = '0;
              q_busy = 1'b0;
              if (q_fill > 0) begin
                r1 = issue_head_move();
                n = 2;
              end
            end
          end else begin
            stable_frames = '0;
          end
        end
      end
      CMD_CANCEL: begin
        if (q_busy) begin
          last_ctrl = last_ctrl | CW_HALT;
          r0.event_res = EV_CANCEL;
          r0.control_out = last_ctrl;
          r0.dropped_moves = q_fill;
          q_head = '0;
          q_fill = '0;
          q_busy = 1'b0;
          stable_frames = '0;
        end
      end
      default: begin
      end
    endcase
    r0.moving = q_busy;
    r0.last_result = (n == 1);
    awaited_results.push_back(r0);
    if (n == 2) begin
      r1.moving = q_busy;
      r1.last_result = 1'b1;
      awaited_results.push_back(r1);
    end
  endfunction

  task automatic push_item(input logic [1:0] cmd, input logic signed [31:0] goal,
                           input logic rel, input logic imm, input logic [3:0] len,
                           input logic [15:0] status, input logic signed [31:0] actual);
    in_item_t it;
    it.command = cmd;
    it.goal_pos = goal;
    it.relative_move = rel;
    it.immediate_move = imm;
    it.frame_length = len;
    it.drive_status = status;
    it.meas_pos = actual;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic logic [3:0] valid_frame_len();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(6, 8));
  endfunction

  function automatic logic [15:0] reached_status();
    return 16'($urandom) | TARGET_BIT;
  endfunction

  // A position within the error limit of the goal, often right on the limit.
  function automatic logic signed [31:0] on_target(input logic signed [31:0] goal);
    longint off, a;
    case ($urandom_range(0, 3))
      0: off = 0;
      1: off = longint'(err_limit);
      default: off = longint'($urandom_range(0, err_limit));
    endcase
    if ($urandom_range(0, 1) == 1) off = -off;
    a = longint'(goal) + off;
    if (a > POS_MAX || a < POS_MIN) a = longint'(goal) - off;
    if (a > POS_MAX || a < POS_MIN) a = longint'(goal);
    return a[31:0];
  endfunction

  // A position one count beyond the limit; fails when that cannot be represented.
  function automatic bit off_target(input logic signed [31:0] goal,
                                    output logic signed [31:0] pos);
    longint off, a;
    pos = goal;
    if (err_limit == '1) return 1'b0;
    off = longint'(err_limit) + 1;
    if ($urandom_range(0, 1) == 1) off = -off;
    a = longint'(goal) + off;
    if (a > POS_MAX || a < POS_MIN) a = longint'(goal) - off;
    if (a > POS_MAX || a < POS_MIN) return 1'b0;
    pos = a[31:0];
    return 1'b1;
  endfunction

  task automatic push_random_item();
    push_item(2'($urandom_range(0, 3)), $urandom, 1'($urandom), 1'($urandom),
              4'($urandom_range(0, 15)), 16'($urandom), $urandom);
  endtask

  // Starts from idle, queues some moves and then walks each one towards completion,
  // with disturbances before the run of good frames and now and then an early stop.
  task automatic push_move_sequence();
    logic signed [31:0] goals[$];
    logic signed [31:0] pos;
    int n_moves, abort_at, run, idx;
    push_item(CMD_CANCEL, $urandom, 1'($urandom), 1'($urandom), 4'($urandom),
              16'($urandom), $urandom);
    if ($urandom_range(0, 9) == 0) n_moves = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 2);
    else n_moves = $urandom_range(1, 4);
    repeat (n_moves) begin
      pos = $urandom;
      push_item(CMD_ENQUEUE, pos, 1'($urandom), 1'($urandom), 4'($urandom),
                16'($urandom), $urandom);
      if (goals.size() < QUEUE_DEPTH) goals.push_back(pos);
    end
    abort_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, goals.size() - 1) : -1;
    idx = 0;
    while (idx < goals.size()) begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0: push_item(CMD_STATUS, $urandom, 1'($urandom), 1'($urandom),
                       4'($urandom_range(0, 5)), reached_status(), on_target(goals[idx]));
          1: push_item(CMD_STATUS, $urandom, 1'($urandom), 1'($urandom), valid_frame_len(),
                       16'($urandom) & ~TARGET_BIT, on_target(goals[idx]));
          2: begin
            if (off_target(goals[idx], pos))
              push_item(CMD_STATUS, $urandom, 1'($urandom), 1'($urandom), valid_frame_len(),
                        reached_status(), pos);
            else
              push_item(CMD_STATUS, $urandom, 1'($urandom), 1'($urandom), valid_frame_len(),
                        16'($urandom) & ~TARGET_BIT, goals[idx]);
          end
          3: begin
            pos = $urandom;
            push_item(CMD_ENQUEUE, pos, 1'($urandom), 1'($urandom), 4'($urandom),
                      16'($urandom), $urandom);
            if (goals.size() - idx < QUEUE_DEPTH) goals.push_back(pos);
          end
          default: push_item(CMD_UNUSED, $urandom, 1'($urandom), 1'($urandom),
                             4'($urandom), 16'($urandom), $urandom);
        endcase
      end
      run = (frames_needed == 0) ? 1 : int'(frames_needed);
      if (run > 8) run = $urandom_range(1, 8);
      if (idx == abort_at) run = $urandom_range(0, run - 1);
      repeat (run)
        push_item(CMD_STATUS, $urandom, 1'($urandom), 1'($urandom), valid_frame_len(),
                  reached_status(), on_target(goals[idx]));
      if (idx == abort_at) break;
      idx++;
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ERROR_LIMIT) err_limit = value;
    else if (idx == REG_STABLE_NEEDED) frames_needed = value[15:0];
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_until_drained();
    int w;
    for (w = 0; w < 50000 && (pending_items.size() != 0 || s_axis_tvalid
         || awaited_results.size() != 0); w++)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] lim, input logic [15:0] need);
    int start;
    write_register(REG_ERROR_LIMIT, lim);
    write_register(REG_STABLE_NEEDED, {16'd0, need});
    settings_used++;
    start = items_queued;
    while (items_queued - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 85) push_move_sequence();
      else push_random_item();
    end
    wait_until_drained();
  endtask

  // Sender: presents the next queued item and predicts its results on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      holding = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_move_results(item_on_bus);
        items_sent++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending_items.size() > 0 && (send_steady || $urandom_range(0, 99) >= 16)) begin
          item_on_bus = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, item_on_bus.meas_pos, item_on_bus.drive_status,
                           item_on_bus.frame_length, item_on_bus.immediate_move,
                           item_on_bus.relative_move, item_on_bus.goal_pos};
          s_axis_tuser <= item_on_bus.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest prediction. Once, while
  // plenty of items are still queued, it holds off long enough to fill the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.event_res = event_e'(m_axis_tuser);
        seen.control_out = m_axis_tdata[15:0];
        seen.setpoint_position = m_axis_tdata[47:16];
        seen.dropped_moves = m_axis_tdata[52:48];
        seen.moving = m_axis_tdata[53];
        seen.last_result = m_axis_tlast;
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Result %0d came with nothing expected: ev=%0d cw=%h pos=%0d",
                     results_seen, seen.event_res, seen.control_out, seen.setpoint_position);
        end else begin
          want = awaited_results.pop_front();
          case (want.event_res)
            EV_SETPOINT: n_setpoints++;
            EV_COMPLETE: n_completions++;
            EV_CANCEL: n_cancels++;
            EV_FULL: n_rejects++;
            default: begin
            end
          endcase
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"Mismatch at result %0d: expected ev=%0d cw=%h pos=%0d drop=%0d ",
                        "moving=%b last=%b, got ev=%0d cw=%h pos=%0d drop=%0d moving=%b last=%b"},
                       results_seen, want.event_res, want.control_out,
                       want.setpoint_position, want.dropped_moves, want.moving,
                       want.last_result, seen.event_res, seen.control_out,
                       seen.setpoint_position, seen.dropped_moves, seen.moving,
                       seen.last_result);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 300 && pending_items.size() > 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= recv_steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  initial begin
    logic [3:0] settle_lens[5];
    logic [15:0] settle_status[5];
    settle_lens = '{4'd6, 4'd7, 4'd8, 4'd15, 4'd9};
    settle_status = '{16'h0400, 16'h0400, 16'h0400, 16'hFFFF, 16'h0400};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values.
    push_item(CMD_CANCEL, 32'sd0, 1'b0, 1'b0, 4'd0, 16'h0000, 32'sd0);
    push_item(CMD_STATUS, 32'sd0, 1'b0, 1'b0, 4'd8, TARGET_BIT, 32'sd0);
    push_item(CMD_UNUSED, '1, 1'b1, 1'b1, 4'hF, 16'hFFFF, '1);
    push_item(CMD_ENQUEUE, 32'sh7FFFFFFF, 1'b1, 1'b1, 4'd0, 16'h0000, 32'sd0);
    push_item(CMD_ENQUEUE, 32'sh80000000, 1'b0, 1'b0, 4'd0, 16'h0000, 32'sd0);
    push_item(CMD_STATUS, 32'sd0, 1'b0, 1'b0, 4'd5, TARGET_BIT, 32'sh7FFFFFFF);
    push_item(CMD_STATUS, 32'sd0, 1'b0, 1'b0, 4'd6, 16'hFBFF, 32'sh7FFFFFFF);
    // Exactly on the error limit; the fifth frame completes and issues the next move.
    for (int i = 0; i < 5; i++)
      push_item(CMD_STATUS, 32'sd0, 1'b0, 1'b0, settle_lens[i], settle_status[i],
                32'sh7FFFFFFF - 32'sd100);
    // Largest possible error: must not wrap around to a small one.
    push_item(CMD_STATUS, 32'sd0, 1'b0, 1'b0, 4'd8, TARGET_BIT, 32'sh7FFFFFFF);
    push_item(CMD_ENQUEUE, 32'sd12345, 1'b1, 1'b0, 4'd0, 16'h0000, 32'sd0);
    push_item(CMD_CANCEL, 32'sd0, 1'b0, 1'b0, 4'd0, 16'h0000, 32'sd0);
    wait_until_drained();

    // Writes past the register map must leave the registers alone.
    write_register(REG_PAST_MAP, 32'd7);
    write_register(REG_LAST_INDEX, 32'hFFFF_FFFF);
    run_phase(32'd0, 16'd0);
    run_phase(32'hFFFF_FFFF, 16'd1);
    run_phase(32'($urandom_range(1, 5000)), 16'($urandom_range(2, 4)));
    run_phase(32'd50, 16'hFFFF);
    run_phase(32'($urandom), 16'd3);

    $display("Ran %0d items and checked %0d results under %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("Seen %0d setpoints, %0d completions, %0d cancels, %0d rejected moves.",
             n_setpoints, n_completions, n_cancels, n_rejects);
    if (awaited_results.size() != 0)
      $display("%0d expected results never arrived", awaited_results.size());
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected", awaited_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
